>>> rtl/scpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scpu_pkg;

    // Coordinate and intermediate widths. Every product below is exact.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int BIG_W   = 2 * DOT_W + 2;

    // Multiplier: signed MA_W by signed MB_W, one DIG_W by DIG_W tile per stage.
    localparam int MA_W    = BIG_W + 2;
    localparam int MB_W    = DOT_W + 2;
    localparam int MP_W    = BIG_W + DIFF_W + 5;
    localparam int DIG_W   = 32;
    localparam int DIG_NA  = (MA_W + DIG_W - 1) / DIG_W;
    localparam int DIG_NB  = (MB_W + DIG_W - 1) / DIG_W;
    localparam int DIG_N   = DIG_NA * DIG_NB;
    localparam int MUL_LAT = DIG_N + 2;

    // Divider: quotient bits and dividend width for the rounded scale step.
    localparam int QB      = DIFF_W;
    localparam int NUM_W   = BIG_W + DIFF_W + 1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Pipeline depths in cycles.
    localparam int FRONT_LAT = MUL_LAT + 6;
    localparam int BACK_LAT  = MUL_LAT + QB + 2;
    localparam int TOTAL_LAT = FRONT_LAT + BACK_LAT + 1;

    typedef logic [2:0][COORD_W-1:0] coord3_t;
    typedef logic [2:0][DIFF_W-1:0]  diff3_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_start_x;
        logic signed [COORD_W-1:0] a_start_y;
        logic signed [COORD_W-1:0] a_start_z;
        logic signed [COORD_W-1:0] a_end_x;
        logic signed [COORD_W-1:0] a_end_y;
        logic signed [COORD_W-1:0] a_end_z;
        logic signed [COORD_W-1:0] b_start_x;
        logic signed [COORD_W-1:0] b_start_y;
        logic signed [COORD_W-1:0] b_start_z;
        logic signed [COORD_W-1:0] b_end_x;
        logic signed [COORD_W-1:0] b_end_y;
        logic signed [COORD_W-1:0] b_end_z;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_a_x;
        logic signed [COORD_W-1:0] near_a_y;
        logic signed [COORD_W-1:0] near_a_z;
        logic signed [COORD_W-1:0] near_b_x;
        logic signed [COORD_W-1:0] near_b_y;
        logic signed [COORD_W-1:0] near_b_z;
        logic                      parallel_flag;
    } result_t;

    // Classified request: clamped segment parameters as fractions plus geometry.
    typedef struct packed {
        coord3_t                 pa;
        coord3_t                 pb;
        diff3_t                  u;
        diff3_t                  v;
        logic signed [BIG_W-1:0] sn;
        logic signed [BIG_W-1:0] sd;
        logic signed [BIG_W-1:0] tn;
        logic signed [BIG_W-1:0] td;
        logic                    par;
    } job_t;

endpackage

`default_nettype wire

>>> rtl/scpu_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_mul (
    input  logic                               clk,
    input  logic signed [scpu_pkg::MA_W-1:0]   a,
    input  logic signed [scpu_pkg::MB_W-1:0]   b,
    output logic signed [scpu_pkg::MP_W-1:0]   p
);
    import scpu_pkg::*;

    localparam int AD_W = DIG_NA * DIG_W;
    localparam int BD_W = DIG_NB * DIG_W;

    logic [MA_W-1:0] ma_abs;
    logic [MB_W-1:0] mb_abs;
    logic [AD_W-1:0] ma_reg  [DIG_N];
    logic [BD_W-1:0] mb_reg  [DIG_N];
    logic            neg_reg [DIG_N+1];
    logic [MP_W-1:0] acc_reg [DIG_N+1];
    logic [MP_W-1:0] p_reg;

    // Operand magnitudes; the sign is reapplied at the end.
    assign ma_abs = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
    assign mb_abs = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);

    // Magnitudes and the product sign enter the first stage.
    always_ff @(posedge clk)
    begin
        ma_reg[0]  <= AD_W'(ma_abs);
        mb_reg[0]  <= BD_W'(mb_abs);
        neg_reg[0] <= a[MA_W-1] ^ b[MB_W-1];
        acc_reg[0] <= '0;
    end

    // One tile of a by one digit of b per stage is added into the running sum.
    for (genvar k = 0; k < DIG_N; k++)
    begin : g_tile
        localparam int IA = k % DIG_NA;
        localparam int IB = k / DIG_NA;

        logic [2*DIG_W-1:0] part;

        assign part = ma_reg[k][IA*DIG_W +: DIG_W] * mb_reg[k][IB*DIG_W +: DIG_W];

        always_ff @(posedge clk)
        begin
            neg_reg[k+1] <= neg_reg[k];
            acc_reg[k+1] <= acc_reg[k] + (MP_W'(part) << ((IA + IB) * DIG_W));
        end

        if (k < DIG_N - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                ma_reg[k+1] <= ma_reg[k];
                mb_reg[k+1] <= mb_reg[k];
            end
        end
    end

    // Signed product.
    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg[DIG_N] ? MP_W'(-acc_reg[DIG_N]) : acc_reg[DIG_N];
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

>>> rtl/scpu_div.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_div (
    input  logic                         clk,
    input  logic [scpu_pkg::NUM_W-1:0]   n,
    input  logic [scpu_pkg::NUM_W-1:0]   d,
    output logic [scpu_pkg::QB-1:0]      q
);
    import scpu_pkg::*;

    logic [NUM_W-1:0] n_reg [QB];
    logic [NUM_W-1:0] d_reg [QB];
    logic [QB-1:0]    q_reg [QB];

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic [NUM_W-1:0] n_in;
        logic [NUM_W-1:0] d_in;
        logic [NUM_W-1:0] ds;
        logic [QB-1:0]    q_in;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign n_in = n;
            assign d_in = d;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign n_in = n_reg[j-1];
            assign d_in = d_reg[j-1];
            assign q_in = q_reg[j-1];
        end

        assign ds = d_in << (QB - 1 - j);
        assign ge = (n_in >= ds);

        always_ff @(posedge clk)
        begin
            n_reg[j] <= ge ? n_in - ds : n_in;
            d_reg[j] <= d_in;
            q_reg[j] <= q_in | (QB'(ge) << (QB - 1 - j));
        end
    end

    assign q = q_reg[QB-1];

endmodule

`default_nettype wire

>>> rtl/scpu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  scpu_pkg::item_t   item,
    output logic              job_valid,
    output scpu_pkg::job_t    job
);
    import scpu_pkg::*;

    typedef logic signed [DOT_W-1:0] dot_t;
    typedef logic signed [BIG_W-1:0] big_t;

    typedef struct packed {
        coord3_t pa;
        coord3_t pb;
        diff3_t  u;
        diff3_t  v;
    } geom_t;

    typedef struct packed {
        geom_t geom;
        dot_t  a;
        dot_t  b;
        dot_t  c;
        dot_t  d;
        dot_t  e;
    } side_t;

    function automatic logic [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y);
        return DIFF_W'(x) - DIFF_W'(y);
    endfunction

    function automatic logic signed [PROD_W-1:0] sx(input logic [DIFF_W-1:0] x);
        return PROD_W'($signed(x));
    endfunction

    function automatic dot_t dsum(input logic signed [PROD_W-1:0] x,
                                  input logic signed [PROD_W-1:0] y,
                                  input logic signed [PROD_W-1:0] z);
        return DOT_W'(x) + DOT_W'(y) + DOT_W'(z);
    endfunction

    function automatic big_t big(input logic signed [MP_W-1:0] x);
        return $signed(x[BIG_W-1:0]);
    endfunction

    function automatic big_t ext(input dot_t x);
        return BIG_W'(x);
    endfunction

    logic [FRONT_LAT-1:0]      valid_reg;
    geom_t                     geom_next;
    geom_t                     geom1_reg;
    geom_t                     geom2_reg;
    geom_t                     geom3_reg;
    diff3_t                    w_next;
    diff3_t                    w1_reg;
    logic signed [PROD_W-1:0]  uu_reg [3];
    logic signed [PROD_W-1:0]  uv_reg [3];
    logic signed [PROD_W-1:0]  vv_reg [3];
    logic signed [PROD_W-1:0]  uw_reg [3];
    logic signed [PROD_W-1:0]  vw_reg [3];
    dot_t                      a_reg;
    dot_t                      b_reg;
    dot_t                      c_reg;
    dot_t                      d_reg;
    dot_t                      e_reg;
    side_t                     side_reg [MUL_LAT];
    logic signed [MP_W-1:0]    ac_p;
    logic signed [MP_W-1:0]    bb_p;
    logic signed [MP_W-1:0]    be_p;
    logic signed [MP_W-1:0]    cd_p;
    logic signed [MP_W-1:0]    ae_p;
    logic signed [MP_W-1:0]    bd_p;
    side_t                     side4_reg;
    big_t                      den4_reg;
    big_t                      sn4_reg;
    big_t                      tn4_reg;
    logic                      par_next;
    big_t                      sn_next;
    big_t                      sd_next;
    big_t                      tn_next;
    big_t                      td_next;
    big_t                      nd_next;
    big_t                      ndb_next;
    geom_t                     geom5_reg;
    logic                      par5_reg;
    big_t                      sn5_reg;
    big_t                      sd5_reg;
    big_t                      tn5_reg;
    big_t                      td5_reg;
    big_t                      nd5_reg;
    big_t                      ndb5_reg;
    big_t                      a5_reg;
    job_t                      job_next;
    job_t                      job_reg;

    // Occupancy of each front stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    // Segment direction vectors and the offset between the two starts.
    always_comb
    begin
        geom_next.pa = {item.a_start_z, item.a_start_y, item.a_start_x};
        geom_next.pb = {item.b_start_z, item.b_start_y, item.b_start_x};
        geom_next.u  = {dif(item.a_end_z, item.a_start_z),
                        dif(item.a_end_y, item.a_start_y),
                        dif(item.a_end_x, item.a_start_x)};
        geom_next.v  = {dif(item.b_end_z, item.b_start_z),
                        dif(item.b_end_y, item.b_start_y),
                        dif(item.b_end_x, item.b_start_x)};
        w_next       = {dif(item.a_start_z, item.b_start_z),
                        dif(item.a_start_y, item.b_start_y),
                        dif(item.a_start_x, item.b_start_x)};
    end

    always_ff @(posedge clk)
    begin
        geom1_reg <= geom_next;
        w1_reg    <= w_next;
    end

    // Per-axis products for the five dot products.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            uu_reg[k] <= sx(geom1_reg.u[k]) * sx(geom1_reg.u[k]);
            uv_reg[k] <= sx(geom1_reg.u[k]) * sx(geom1_reg.v[k]);
            vv_reg[k] <= sx(geom1_reg.v[k]) * sx(geom1_reg.v[k]);
            uw_reg[k] <= sx(geom1_reg.u[k]) * sx(w1_reg[k]);
            vw_reg[k] <= sx(geom1_reg.v[k]) * sx(w1_reg[k]);
        end
        geom2_reg <= geom1_reg;
    end

    // Dot products a, b, c, d, e.
    always_ff @(posedge clk)
    begin
        a_reg     <= dsum(uu_reg[0], uu_reg[1], uu_reg[2]);
        b_reg     <= dsum(uv_reg[0], uv_reg[1], uv_reg[2]);
        c_reg     <= dsum(vv_reg[0], vv_reg[1], vv_reg[2]);
        d_reg     <= dsum(uw_reg[0], uw_reg[1], uw_reg[2]);
        e_reg     <= dsum(vw_reg[0], vw_reg[1], vw_reg[2]);
        geom3_reg <= geom2_reg;
    end

    // Second-order products through six pipelined multipliers, one per product.
    scpu_mul u_mul_ac (.clk(clk), .a(MA_W'(a_reg)), .b(MB_W'(c_reg)), .p(ac_p));
    scpu_mul u_mul_bb (.clk(clk), .a(MA_W'(b_reg)), .b(MB_W'(b_reg)), .p(bb_p));
    scpu_mul u_mul_be (.clk(clk), .a(MA_W'(b_reg)), .b(MB_W'(e_reg)), .p(be_p));
    scpu_mul u_mul_cd (.clk(clk), .a(MA_W'(c_reg)), .b(MB_W'(d_reg)), .p(cd_p));
    scpu_mul u_mul_ae (.clk(clk), .a(MA_W'(a_reg)), .b(MB_W'(e_reg)), .p(ae_p));
    scpu_mul u_mul_bd (.clk(clk), .a(MA_W'(b_reg)), .b(MB_W'(d_reg)), .p(bd_p));

    // Geometry and dot products ride alongside the multipliers.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= {geom3_reg, a_reg, b_reg, c_reg, d_reg, e_reg};
        for (int k = 1; k < MUL_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Denominator and unclamped numerators.
    always_ff @(posedge clk)
    begin
        den4_reg  <= big(ac_p) - big(bb_p);
        sn4_reg   <= big(be_p) - big(cd_p);
        tn4_reg   <= big(ae_p) - big(bd_p);
        side4_reg <= side_reg[MUL_LAT-1];
    end

    // Parallel test and clamp of s to the segment.
    always_comb
    begin
        par_next = (den4_reg <= 0);
        sn_next  = sn4_reg;
        sd_next  = den4_reg;
        tn_next  = tn4_reg;
        td_next  = den4_reg;
        if (par_next)
        begin
            sn_next = '0;
            sd_next = big_t'(1);
            tn_next = ext(side4_reg.e);
            td_next = ext(side4_reg.c);
        end
        else if (sn4_reg < 0)
        begin
            sn_next = '0;
            tn_next = ext(side4_reg.e);
            td_next = ext(side4_reg.c);
        end
        else if (den4_reg < sn4_reg)
        begin
            sn_next = den4_reg;
            tn_next = ext(side4_reg.e) + ext(side4_reg.b);
            td_next = ext(side4_reg.c);
        end
        nd_next  = -ext(side4_reg.d);
        ndb_next = ext(side4_reg.b) - ext(side4_reg.d);
    end

    always_ff @(posedge clk)
    begin
        geom5_reg <= side4_reg.geom;
        par5_reg  <= par_next;
        sn5_reg   <= sn_next;
        sd5_reg   <= sd_next;
        tn5_reg   <= tn_next;
        td5_reg   <= td_next;
        nd5_reg   <= nd_next;
        ndb5_reg  <= ndb_next;
        a5_reg    <= ext(side4_reg.a);
    end

    // Clamp of t, recomputing s when t hits an end of its segment.
    always_comb
    begin
        job_next.pa  = geom5_reg.pa;
        job_next.pb  = geom5_reg.pb;
        job_next.u   = geom5_reg.u;
        job_next.v   = geom5_reg.v;
        job_next.par = par5_reg;
        job_next.sn  = sn5_reg;
        job_next.sd  = sd5_reg;
        job_next.tn  = tn5_reg;
        job_next.td  = td5_reg;
        if (tn5_reg < 0)
        begin
            job_next.tn = '0;
            if (nd5_reg < 0)
            begin
                job_next.sn = '0;
            end
            else if (a5_reg < nd5_reg)
            begin
                job_next.sn = sd5_reg;
            end
            else
            begin
                job_next.sn = nd5_reg;
                job_next.sd = a5_reg;
            end
        end
        else if (td5_reg < tn5_reg)
        begin
            job_next.tn = td5_reg;
            if (ndb5_reg < 0)
            begin
                job_next.sn = '0;
            end
            else if (a5_reg < ndb5_reg)
            begin
                job_next.sn = sd5_reg;
            end
            else
            begin
                job_next.sn = ndb5_reg;
                job_next.sd = a5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = valid_reg[FRONT_LAT-1];
    assign job       = job_reg;

endmodule

`default_nettype wire

>>> rtl/scpu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  scpu_pkg::job_t    push_job,
    output logic              head_valid,
    output scpu_pkg::job_t    head_job,
    output logic              full
);
    import scpu_pkg::*;

    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;
    job_t             mem_reg [QUEUE_DEPTH];

    // The back takes the head request in every cycle that one is present.
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid;
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_job   = mem_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/scpu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  scpu_pkg::job_t      head_job,
    output logic                done,
    output scpu_pkg::result_t   result
);
    import scpu_pkg::*;

    localparam int LANES = 6;

    typedef struct packed {
        logic [BIG_W-1:0]   den;
        logic               neg;
        logic               zero;
        logic [COORD_W-1:0] base;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic              par;
    } bside_t;

    logic [BACK_LAT-1:0]     valid_reg;
    lane_t [LANES-1:0]       lane_next;
    lane_t [LANES-1:0]       lane0_reg;
    logic signed [BIG_W-1:0] num_next [LANES];
    logic signed [BIG_W-1:0] num0_reg [LANES];
    logic [DIFF_W-1:0]       mag_next [LANES];
    logic [DIFF_W-1:0]       mag0_reg [LANES];
    logic                    par0_reg;
    bside_t                  mside_reg [MUL_LAT];
    bside_t                  dside_reg [QB];
    logic signed [MP_W-1:0]  prod [LANES];
    logic [NUM_W-1:0]        div_n [LANES];
    logic [NUM_W-1:0]        div_d [LANES];
    logic [QB-1:0]           quot [LANES];
    logic [COORD_W-1:0]      pt [LANES];
    result_t                 result_next;
    result_t                 result_reg;

    // Occupancy of each back stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[BACK_LAT-2:0], head_valid};
        end
    end

    // Split the request into six lanes: fraction, axis delta and start point.
    always_comb
    begin
        logic signed [BIG_W-1:0] den;
        logic signed [DIFF_W-1:0] delta;
        for (int s = 0; s < 2; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (s == 0)
                begin
                    num_next[s*3+k]       = head_job.sn;
                    den                   = head_job.sd;
                    delta                 = $signed(head_job.u[k]);
                    lane_next[s*3+k].base = head_job.pa[k];
                end
                else
                begin
                    num_next[s*3+k]       = head_job.tn;
                    den                   = head_job.td;
                    delta                 = $signed(head_job.v[k]);
                    lane_next[s*3+k].base = head_job.pb[k];
                end
                lane_next[s*3+k].den  = den;
                lane_next[s*3+k].neg  = delta[DIFF_W-1];
                lane_next[s*3+k].zero = (num_next[s*3+k] == '0) || (den <= 0);
                mag_next[s*3+k]       = delta[DIFF_W-1] ? DIFF_W'(-delta) : DIFF_W'(delta);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane0_reg <= lane_next;
        par0_reg  <= head_job.par;
        for (int l = 0; l < LANES; l++)
        begin
            num0_reg[l] <= num_next[l];
            mag0_reg[l] <= mag_next[l];
        end
    end

    // Lane bookkeeping delayed alongside the multipliers and dividers.
    always_ff @(posedge clk)
    begin
        mside_reg[0] <= {lane0_reg, par0_reg};
        for (int k = 1; k < MUL_LAT; k++)
        begin
            mside_reg[k] <= mside_reg[k-1];
        end
        dside_reg[0] <= mside_reg[MUL_LAT-1];
        for (int k = 1; k < QB; k++)
        begin
            dside_reg[k] <= dside_reg[k-1];
        end
    end

    // Each lane: |num * delta|, then round to nearest over den.
    for (genvar gl = 0; gl < LANES; gl++)
    begin : g_lane
        scpu_mul u_mul (
            .clk (clk),
            .a   (MA_W'(num0_reg[gl])),
            .b   ($signed(MB_W'(mag0_reg[gl]))),
            .p   (prod[gl])
        );

        assign div_n[gl] = {prod[gl][NUM_W-2:0], 1'b0}
                         + NUM_W'(mside_reg[MUL_LAT-1].lane[gl].den);
        assign div_d[gl] = NUM_W'({mside_reg[MUL_LAT-1].lane[gl].den, 1'b0});

        scpu_div u_div (
            .clk (clk),
            .n   (div_n[gl]),
            .d   (div_d[gl]),
            .q   (quot[gl])
        );
    end

    // Closest points: start plus signed rounded offset.
    always_comb
    begin
        logic [DIFF_W-1:0] off;
        for (int l = 0; l < LANES; l++)
        begin
            if (dside_reg[QB-1].lane[l].zero)
            begin
                off = '0;
            end
            else if (dside_reg[QB-1].lane[l].neg)
            begin
                off = -DIFF_W'(quot[l]);
            end
            else
            begin
                off = DIFF_W'(quot[l]);
            end
            pt[l] = COORD_W'(DIFF_W'($signed(dside_reg[QB-1].lane[l].base)) + off);
        end
        result_next.near_a_x      = $signed(pt[0]);
        result_next.near_a_y      = $signed(pt[1]);
        result_next.near_a_z      = $signed(pt[2]);
        result_next.near_b_x      = $signed(pt[3]);
        result_next.near_b_y      = $signed(pt[4]);
        result_next.near_b_z      = $signed(pt[5]);
        result_next.parallel_flag = dside_reg[QB-1].par;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg[BACK_LAT-1];
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/segment_closest_points_3d_unit.sv
// Closest points between two 3D segments, signed Q15.16 coordinates.
//
// Request channel: drive item and raise start; the request is taken on a
// rising edge where start is high and busy is low. One request can be taken
// in every cycle.
// Result channel: done is high for exactly one cycle with result holding
// both closest points and the parallel flag. The receiver cannot stall it.
//
// A request passes from the accepting edge to the result through the front
// (differences, per-axis products, dot products, the pipelined multiplier
// for the second-order products, the denominator and two clamp stages),
// the queue, and the back (lane split, multiplier, 33-stage restoring
// divider, final add).
// Throughput is one request per cycle while busy is low; every multiplier
// and divider stage is pipelined.
// busy rises only if the two-entry queue between front and back fills; the
// back drains it every cycle, so busy stays low in normal use.
// Reset clears the valid bits of both pipelines and the queue; requests in
// flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module segment_closest_points_3d_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  scpu_pkg::item_t     item,
    output logic                done,
    output scpu_pkg::result_t   result
);
    import scpu_pkg::*;

    logic job_valid;
    job_t job;
    logic head_valid;
    job_t head_job;

    scpu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .item      (item),
        .job_valid (job_valid),
        .job       (job)
    );

    scpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (busy)
    );

    scpu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .done       (done),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> rtl/scpu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scpu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input scpu_pkg::item_t     item,
    input logic                done,
    input scpu_pkg::result_t   result
);
    import scpu_pkg::*;

    logic accept;
    logic a_point;

    assign accept  = start && !busy;
    assign a_point = (item.a_start_x == item.a_end_x) && (item.a_start_y == item.a_end_y)
                  && (item.a_start_z == item.a_end_z);

    // Every accepted request yields a result after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("accepted request produced no result");

    // No result appears without a request taken the fixed latency before.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LAT))
        else $error("result without a matching request");

    // A first segment collapsed to a point returns that point and is parallel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && a_point) |-> ##TOTAL_LAT
            (result.near_a_x == $past(item.a_start_x, TOTAL_LAT)
             && result.near_a_y == $past(item.a_start_y, TOTAL_LAT)
             && result.near_a_z == $past(item.a_start_z, TOTAL_LAT)
             && result.parallel_flag))
        else $error("degenerate first segment gave a wrong point");

endmodule

bind segment_closest_points_3d_unit scpu_checker u_checker (.*);

`default_nettype wire

>>> tb/tb_segment_closest_points_3d_unit.sv
`timescale 1ns / 1ps

module tb_segment_closest_points_3d_unit;

    import scpu_pkg::*;

    localparam int ONE_Q   = 1 << 16;
    localparam int N_RAND  = 1200;
    localparam int WD_MAX  = 4000;
    localparam int DRAIN   = TOTAL_LAT + 20;

    typedef logic signed [319:0] wide_t;

    // Shapes of random request.
    typedef enum int {
        SHAPE_RAW,
        SHAPE_SMALL,
        SHAPE_PARALLEL,
        SHAPE_DEGENERATE,
        SHAPE_SHARED
    } shape_t;

    // One directed row: request, and a typed-in answer where obvious.
    typedef struct {
        item_t   req;
        bit      typed;
        result_t ans;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    result_t pending_points[$];
    int      mismatches;
    int      results_seen;
    int      parallel_seen;
    int      accepted;
    int      stall_cycles;
    bit      timed_out;

    segment_closest_points_3d_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Round num*delta/den to nearest, ties away from zero; 0 for empty cases.
    function automatic wide_t scaled_offset(wide_t num, wide_t den, wide_t delta);
        wide_t p;
        wide_t m;
        wide_t q;
        if (num == 0 || den <= 0)
            return 0;
        p = num * delta;
        m = (p < 0) ? -p : p;
        q = ((m <<< 1) + den) / (den <<< 1);
        return (p < 0) ? -q : q;
    endfunction

    // Exact closest points between the two segments of one request.
    function automatic result_t closest_points(item_t it);
        wide_t   pa[3];
        wide_t   pb[3];
        wide_t   u[3];
        wide_t   v[3];
        wide_t   w[3];
        wide_t   a, b, c, d, e, den, sn, sd, tn, td, nd, ndb;
        wide_t   pt;
        bit      par;
        result_t r;
        pa[0] = wide_t'(it.a_start_x); pa[1] = wide_t'(it.a_start_y);
        pa[2] = wide_t'(it.a_start_z);
        pb[0] = wide_t'(it.b_start_x); pb[1] = wide_t'(it.b_start_y);
        pb[2] = wide_t'(it.b_start_z);
        u[0] = wide_t'(it.a_end_x) - pa[0]; u[1] = wide_t'(it.a_end_y) - pa[1];
        u[2] = wide_t'(it.a_end_z) - pa[2];
        v[0] = wide_t'(it.b_end_x) - pb[0]; v[1] = wide_t'(it.b_end_y) - pb[1];
        v[2] = wide_t'(it.b_end_z) - pb[2];
        for (int k = 0; k < 3; k++)
            w[k] = pa[k] - pb[k];
        a = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        b = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        c = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        d = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
        e = v[0] * w[0] + v[1] * w[1] + v[2] * w[2];
        den = a * c - b * b;

        // Parallel pair pins s at the start; otherwise clamp s first.
        par = !(den > 0);
        sd = den;
        td = den;
        if (par)
        begin
            sn = 0; sd = 1; tn = e; td = c;
        end
        else
        begin
            sn = b * e - c * d;
            tn = a * e - b * d;
            if (sn < 0)
            begin
                sn = 0; tn = e; td = c;
            end
            else if (sd < sn)
            begin
                sn = sd; tn = e + b; td = c;
            end
        end

        // Clamp t and recompute s against the clamped end.
        nd  = -d;
        ndb = nd + b;
        if (tn < 0)
        begin
            tn = 0;
            if (nd < 0)
                sn = 0;
            else if (a < nd)
                sn = sd;
            else
            begin
                sn = nd; sd = a;
            end
        end
        else if (td < tn)
        begin
            tn = td;
            if (ndb < 0)
                sn = 0;
            else if (a < ndb)
                sn = sd;
            else
            begin
                sn = ndb; sd = a;
            end
        end

        pt = pa[0] + scaled_offset(sn, sd, u[0]); r.near_a_x = pt[COORD_W-1:0];
        pt = pa[1] + scaled_offset(sn, sd, u[1]); r.near_a_y = pt[COORD_W-1:0];
        pt = pa[2] + scaled_offset(sn, sd, u[2]); r.near_a_z = pt[COORD_W-1:0];
        pt = pb[0] + scaled_offset(tn, td, v[0]); r.near_b_x = pt[COORD_W-1:0];
        pt = pb[1] + scaled_offset(tn, td, v[1]); r.near_b_y = pt[COORD_W-1:0];
        pt = pb[2] + scaled_offset(tn, td, v[2]); r.near_b_z = pt[COORD_W-1:0];
        r.parallel_flag = par;
        return r;
    endfunction

    function automatic item_t segment_pair(int ax0, int ay0, int az0, int ax1, int ay1,
                                           int az1, int bx0, int by0, int bz0, int bx1,
                                           int by1, int bz1);
        item_t it;
        it.a_start_x = ax0; it.a_start_y = ay0; it.a_start_z = az0;
        it.a_end_x   = ax1; it.a_end_y   = ay1; it.a_end_z   = az1;
        it.b_start_x = bx0; it.b_start_y = by0; it.b_start_z = bz0;
        it.b_end_x   = bx1; it.b_end_y   = by1; it.b_end_z   = bz1;
        return it;
    endfunction

    function automatic int small_coord();
        return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    // Random request of a randomly chosen shape.
    function automatic item_t random_pair();
        item_t  it;
        shape_t shape;
        int     p[3];
        int     dir[3];
        int     off[3];
        int     m;
        shape = shape_t'($urandom_range(0, 4));
        for (int k = 0; k < 3; k++)
        begin
            p[k]   = small_coord();
            dir[k] = small_coord();
            off[k] = small_coord();
        end
        m = $signed($urandom_range(0, 6)) - 3;
        case (shape)
            SHAPE_RAW:
                it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            SHAPE_PARALLEL:
                it = segment_pair(p[0], p[1], p[2], p[0] + dir[0], p[1] + dir[1],
                                  p[2] + dir[2], p[0] + off[0], p[1] + off[1],
                                  p[2] + off[2], p[0] + off[0] + m * dir[0],
                                  p[1] + off[1] + m * dir[1], p[2] + off[2] + m * dir[2]);
            SHAPE_DEGENERATE:
                it = segment_pair(p[0], p[1], p[2], p[0], p[1], p[2], off[0], off[1],
                                  off[2], (m > 0) ? off[0] : dir[0], dir[1], dir[2]);
            SHAPE_SHARED:
                it = segment_pair(p[0], p[1], p[2], dir[0], dir[1], dir[2], dir[0],
                                  dir[1], dir[2], off[0], off[1], off[2]);
            default:
                it = segment_pair(p[0], p[1], p[2], dir[0], dir[1], dir[2], off[0],
                                  off[1], off[2], small_coord(), small_coord(),
                                  small_coord());
        endcase
        return it;
    endfunction

    task automatic report_mismatch(string field, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // Compare each result with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                $display("[%0t] result with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_points.pop_front();
                if (want.parallel_flag)
                    parallel_seen++;
                if (result.near_a_x !== want.near_a_x)
                    report_mismatch("near_a_x", result.near_a_x, want.near_a_x);
                if (result.near_a_y !== want.near_a_y)
                    report_mismatch("near_a_y", result.near_a_y, want.near_a_y);
                if (result.near_a_z !== want.near_a_z)
                    report_mismatch("near_a_z", result.near_a_z, want.near_a_z);
                if (result.near_b_x !== want.near_b_x)
                    report_mismatch("near_b_x", result.near_b_x, want.near_b_x);
                if (result.near_b_y !== want.near_b_y)
                    report_mismatch("near_b_y", result.near_b_y, want.near_b_y);
                if (result.near_b_z !== want.near_b_z)
                    report_mismatch("near_b_z", result.near_b_z, want.near_b_z);
                if (result.parallel_flag !== want.parallel_flag)
                    report_mismatch("parallel_flag", result.parallel_flag,
                                    want.parallel_flag);
            end
        end
    end

    // Watchdog on cycles with no progress on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= WD_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding",
                     pending_points.size());
            $display("segment_closest_points_3d_unit regression: fail");
            $finish;
        end
    end

    // Present one request from the falling edge until it is taken.
    task automatic send_request(item_t req, result_t ans, bit no_idle);
        while (!no_idle && $urandom_range(0, 99) < 28)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom});
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= req;
        do
            @(posedge clk);
        while (busy);
        pending_points.push_back(ans);
        accepted++;
    endtask

    initial
    begin
        row_t    rows[$];
        row_t    r;
        result_t zero_res;
        int      mx;
        int      mn;
        int      q;
        mismatches    = 0;
        results_seen  = 0;
        parallel_seen = 0;
        accepted      = 0;
        stall_cycles  = 0;
        timed_out     = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        mx = 32'h7fffffff;
        mn = 32'h80000000;
        q  = ONE_Q;
        zero_res = '0;

        // Directed rows: extremes first, then each clamping branch.
        r.typed = 1'b1; r.req = '0; r.ans = zero_res; r.ans.parallel_flag = 1'b1;
        rows.push_back(r);
        r.req = segment_pair(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
        r.ans = {mx, mx, mx, mx, mx, mx, 1'b1};
        rows.push_back(r);
        r.req = segment_pair(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn);
        r.ans = {mn, mn, mn, mn, mn, mn, 1'b1};
        rows.push_back(r);
        r.req = segment_pair(-q, 0, 0, q, 0, 0, 0, -q, q, 0, q, q);
        r.ans = {32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, q, 1'b0};
        rows.push_back(r);
        r.typed = 1'b0;
        rows.push_back('{segment_pair(mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn), 0, '0});
        rows.push_back('{segment_pair(mn, mx, mn, mx, mn, mx, mx, mx, mn, mn, mn, mx), 0, '0});
        rows.push_back('{segment_pair(mx, 0, mn, mn, 0, mx, 0, mx, 0, 0, mn, 0), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, q, 0, 0, -3*q, q, 0, -2*q, -q, 0), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, q, 0, 0, 3*q, q, 0, 4*q, -q, 0), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 4*q, 0, 0, q, -3*q, q, q, -2*q, q), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 4*q, 0, 0, q, 2*q, q, q, 3*q, q), 0, '0});
        rows.push_back('{segment_pair(q, q, q, q, q, q, 0, 0, 0, 2*q, 3*q, -q), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 2*q, q, 5, q, 7, q, q, 7, q), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 2*q, 0, 0, q, q, 0, 5*q, q, 0), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 2*q, 0, 0, -5*q, q, 0, -3*q, q, 0), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, q, 0, 0, q, 0, 0, 2*q, q, 0), 0, '0});
        rows.push_back('{segment_pair(1, 2, 3, -1, -2, -3, 3, 2, 1, -3, -2, -1), 0, '0});
        rows.push_back('{segment_pair(0, 0, 0, 3, 0, 0, 1, 1, 0, 1, -2, 0), 0, '0});

        foreach (rows[i])
            send_request(rows[i].req,
                         rows[i].typed ? rows[i].ans : closest_points(rows[i].req), 1'b0);

        // Random part, with a stretch in the middle at full rate.
        for (int n = 0; n < N_RAND; n++)
        begin
            r.req = random_pair();
            send_request(r.req, closest_points(r.req), n >= 400 && n < 600);
        end
        @(negedge clk);
        start <= 1'b0;

        wait (pending_points.size() == 0);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests (%0d directed), %0d results, %0d parallel",
                 accepted, rows.size(), results_seen, parallel_seen);
        $display("%0d field mismatches", mismatches);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("segment_closest_points_3d_unit regression: pass");
        else
            $display("segment_closest_points_3d_unit regression: fail");
        $finish;
    end

endmodule

>>> segment_closest_points_3d_unit.f
rtl/scpu_pkg.sv
rtl/scpu_mul.sv
rtl/scpu_div.sv
rtl/scpu_front.sv
rtl/scpu_queue.sv
rtl/scpu_back.sv
rtl/segment_closest_points_3d_unit.sv
rtl/scpu_checker.sv
tb/tb_segment_closest_points_3d_unit.sv
